@@ rtl/core/pgsg_pkg.sv @@
// ----------------------------------------------------------------------------
// pgsg_pkg
// Shared types and constants of the polargraph step generator: item and
// result payloads, register indexes, action codes and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package pgsg_pkg;

    // Coordinate width of targets and anchors, length width in whole steps.
    localparam int COORD_BITS = 24;
    localparam int LEN_BITS   = 20;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ANCHOR_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ANCHOR_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Y       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LEFT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_RIGHT   = 3'd4;

    // Item action codes.
    localparam logic ACT_TARGET = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Input item.
    typedef struct packed {
        logic                         action;
        logic signed [COORD_BITS-1:0] pen_x;
        logic signed [COORD_BITS-1:0] pen_y;
    } item_t;

    // Result item.
    typedef struct packed {
        logic                step_left;
        logic                dir_left;
        logic                step_right;
        logic                dir_right;
        logic                busy_res;
        logic                last_step;
        logic                rejected;
        logic [LEN_BITS-1:0] left_length;
        logic [LEN_BITS-1:0] right_length;
    } result_t;

    // Commands from the sequencer to the stepper.
    typedef struct packed {
        logic tick;
        logic plan;
        logic commit;
    } step_cmd_t;

    // Stepper status seen by the sequencer.
    typedef struct packed {
        logic                busy;
        logic [1:0]          dir_bits;
        logic [LEN_BITS-1:0] left_len;
        logic [LEN_BITS-1:0] right_len;
        logic                step_left;
        logic                step_right;
        logic                last;
    } step_status_t;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_PLAN,
        ST_COMMIT,
        ST_EMIT
    } seq_state_t;

    // Length unit states.
    typedef enum logic [2:0] {
        LU_IDLE,
        LU_ABS,
        LU_MUL,
        LU_LOAD,
        LU_ROOT,
        LU_ROUND,
        LU_DONE
    } lu_state_t;

endpackage

`default_nettype wire

@@ rtl/core/pgsg_len_unit.sv @@
// ----------------------------------------------------------------------------
// pgsg_len_unit
// String length of one anchor: squares the two coordinate distances with a
// bit-serial shift-add multiplier, takes a restoring square root two radicand
// bits per cycle, then rounds to whole steps and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module pgsg_len_unit #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [pgsg_pkg::COORD_BITS-1:0]    pen_x,
    input  wire logic [pgsg_pkg::COORD_BITS-1:0]    pen_y,
    input  wire logic [pgsg_pkg::COORD_BITS-1:0]    anchor_x,
    input  wire logic [pgsg_pkg::COORD_BITS-1:0]    anchor_y,
    output logic                                    done,
    output logic [pgsg_pkg::LEN_BITS-1:0]           length
);

    localparam int CB    = pgsg_pkg::COORD_BITS;
    localparam int LB    = pgsg_pkg::LEN_BITS;
    localparam int DW    = CB + 1;
    localparam int AXB   = LB + FRAC_BITS;
    localparam int MAG_W = (CB < AXB) ? CB : AXB;
    localparam int SQ_W  = 2 * MAG_W + 1;
    localparam int M_W   = SQ_W + 2 - 2 * FRAC_BITS;
    localparam int R_W   = (M_W + 1) / 2;
    localparam int ME_W  = 2 * R_W;
    localparam int NW    = ((R_W > LB) ? R_W : LB) + 1;
    localparam int MAXC  = (MAG_W > R_W) ? MAG_W : R_W;
    localparam int CNT_W = $clog2(MAXC);

    pgsg_pkg::lu_state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;

    logic [DW-1:0]    diff_x_reg, diff_y_reg;
    logic [MAG_W-1:0] mag_x_reg, mag_y_reg;
    logic [MAG_W-1:0] sr_x_reg, sr_y_reg;
    logic             sat_reg;
    logic [SQ_W-1:0]  acc_reg;
    logic [ME_W-1:0]  rad_reg;
    logic [R_W+1:0]   rem_reg;
    logic [R_W-1:0]   root_reg;
    logic [LB-1:0]    len_reg;

    // Absolute distances and the out-of-range check.
    logic [DW-1:0] abs_x_full, abs_y_full;
    logic [CB-1:0] abs_x, abs_y;
    logic          sat_x, sat_y;

    always_comb
    begin
        abs_x_full = diff_x_reg[DW-1] ? (~diff_x_reg + DW'(1)) : diff_x_reg;
        abs_y_full = diff_y_reg[DW-1] ? (~diff_y_reg + DW'(1)) : diff_y_reg;
        abs_x      = abs_x_full[CB-1:0];
        abs_y      = abs_y_full[CB-1:0];
        sat_x      = (abs_x >> AXB) != '0;
        sat_y      = (abs_y >> AXB) != '0;
    end

    // One multiplier bit per cycle, most significant first, both squares at once.
    logic [SQ_W-1:0] acc_next;

    always_comb
    begin
        acc_next = (acc_reg << 1)
                 + (sr_x_reg[MAG_W-1] ? SQ_W'(mag_x_reg) : '0)
                 + (sr_y_reg[MAG_W-1] ? SQ_W'(mag_y_reg) : '0);
    end

    // Radicand: four times the sum of squares, scaled down by the fraction bits.
    logic [SQ_W+1:0] acc_ext;
    logic [M_W-1:0]  rad_val;

    always_comb
    begin
        acc_ext = {acc_reg, 2'b00};
        rad_val = acc_ext[SQ_W+1:2*FRAC_BITS];
    end

    // One restoring root step: two radicand bits in, one root bit out.
    logic [R_W+3:0] cand, trial, cand_diff;
    logic           ge;

    always_comb
    begin
        cand      = {rem_reg, rad_reg[ME_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        cand_diff = cand - trial;
        ge        = cand >= trial;
    end

    // Round half up to whole steps and saturate.
    logic [NW-1:0] root_ext, half_val;
    logic [LB-1:0] len_next;

    always_comb
    begin
        root_ext = NW'(root_reg);
        half_val = (root_ext + NW'(1)) >> 1;
        if (sat_reg || ((half_val >> LB) != '0))
            len_next = pgsg_pkg::LEN_MAX;
        else
            len_next = half_val[LB-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgsg_pkg::LU_IDLE:  if (start) state_next = pgsg_pkg::LU_ABS;
            pgsg_pkg::LU_ABS:   state_next = pgsg_pkg::LU_MUL;
            pgsg_pkg::LU_MUL:   if (cnt_reg == '0) state_next = pgsg_pkg::LU_LOAD;
            pgsg_pkg::LU_LOAD:  state_next = pgsg_pkg::LU_ROOT;
            pgsg_pkg::LU_ROOT:  if (cnt_reg == '0) state_next = pgsg_pkg::LU_ROUND;
            pgsg_pkg::LU_ROUND: state_next = pgsg_pkg::LU_DONE;
            pgsg_pkg::LU_DONE:  state_next = pgsg_pkg::LU_IDLE;
            default:            state_next = pgsg_pkg::LU_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        done   = (state_reg == pgsg_pkg::LU_DONE);
        length = len_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pgsg_pkg::LU_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pgsg_pkg::LU_ABS)
                cnt_reg <= CNT_W'(MAG_W - 1);
            else if (state_reg == pgsg_pkg::LU_LOAD)
                cnt_reg <= CNT_W'(R_W - 1);
            else if (state_reg == pgsg_pkg::LU_MUL || state_reg == pgsg_pkg::LU_ROOT)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pgsg_pkg::LU_IDLE:
            begin
                if (start)
                begin
                    diff_x_reg <= {pen_x[CB-1], pen_x} - {anchor_x[CB-1], anchor_x};
                    diff_y_reg <= {pen_y[CB-1], pen_y} - {anchor_y[CB-1], anchor_y};
                end
            end
            pgsg_pkg::LU_ABS:
            begin
                mag_x_reg <= abs_x[MAG_W-1:0];
                mag_y_reg <= abs_y[MAG_W-1:0];
                sr_x_reg  <= abs_x[MAG_W-1:0];
                sr_y_reg  <= abs_y[MAG_W-1:0];
                sat_reg   <= sat_x || sat_y;
                acc_reg   <= '0;
            end
            pgsg_pkg::LU_MUL:
            begin
                acc_reg  <= acc_next;
                sr_x_reg <= sr_x_reg << 1;
                sr_y_reg <= sr_y_reg << 1;
            end
            pgsg_pkg::LU_LOAD:
            begin
                rad_reg  <= ME_W'(rad_val);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            pgsg_pkg::LU_ROOT:
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= ge ? cand_diff[R_W+1:0] : cand[R_W+1:0];
                root_reg <= {root_reg[R_W-2:0], ge};
            end
            pgsg_pkg::LU_ROUND:
            begin
                len_reg <= len_next;
            end
            pgsg_pkg::LU_DONE:
            begin
                len_reg <= len_reg;
            end
            default:
            begin
                len_reg <= len_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/pgsg_stepper.sv @@
// ----------------------------------------------------------------------------
// pgsg_stepper
// Move state and Bresenham interleave of the two motors: plans a move from
// new string lengths and gives one lead step per tick, plus a follower step
// whenever the error sum wraps.
// ----------------------------------------------------------------------------
`default_nettype none

module pgsg_stepper (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pgsg_pkg::step_cmd_t                cmd,
    input  wire logic [pgsg_pkg::LEN_BITS-1:0]      new_left,
    input  wire logic [pgsg_pkg::LEN_BITS-1:0]      new_right,
    output pgsg_pkg::step_status_t                  status
);

    localparam int LB = pgsg_pkg::LEN_BITS;

    // Move state.
    logic [LB-1:0] left_now_reg, right_now_reg;
    logic [LB-1:0] follow_reg, gap_reg;
    logic [LB-1:0] togo_reg, err_reg;
    logic          left_leads_reg;
    logic [1:0]    dir_bits_reg;
    logic          ev_left_reg, ev_right_reg, ev_last_reg;

    // Plan results, held for the commit cycle.
    logic [LB-1:0] dl_reg, dr_reg;
    logic          grow_l_reg, grow_r_reg;

    // Step differences and directions from the new lengths.
    logic          grow_l, grow_r;
    logic [LB-1:0] dl, dr;

    always_comb
    begin
        grow_l = new_left > left_now_reg;
        grow_r = new_right > right_now_reg;
        dl     = grow_l ? (new_left - left_now_reg) : (left_now_reg - new_left);
        dr     = grow_r ? (new_right - right_now_reg) : (right_now_reg - new_right);
    end

    // Lead and follower counts; the right motor leads on a tie.
    logic          left_leads;
    logic [LB-1:0] lead_val, follow_val;

    always_comb
    begin
        left_leads = dl_reg > dr_reg;
        lead_val   = left_leads ? dl_reg : dr_reg;
        follow_val = left_leads ? dr_reg : dl_reg;
    end

    // The follower steps when error plus follow count reaches the lead count.
    logic          busy;
    logic          fstep;
    logic [LB-1:0] err_next;

    always_comb
    begin
        busy     = togo_reg != '0;
        fstep    = err_reg >= gap_reg;
        err_next = fstep ? (err_reg - gap_reg) : (err_reg + follow_reg);
    end

    // Status.
    always_comb
    begin
        status.busy       = busy;
        status.dir_bits   = dir_bits_reg;
        status.left_len   = left_now_reg;
        status.right_len  = right_now_reg;
        status.step_left  = ev_left_reg;
        status.step_right = ev_right_reg;
        status.last       = ev_last_reg;
    end

    // Plan registers.
    always_ff @(posedge clk)
    begin
        if (cmd.plan)
        begin
            dl_reg     <= dl;
            dr_reg     <= dr;
            grow_l_reg <= grow_l;
            grow_r_reg <= grow_r;
        end
    end

    // Move state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_now_reg   <= '0;
            right_now_reg  <= '0;
            follow_reg     <= '0;
            gap_reg        <= '0;
            togo_reg       <= '0;
            err_reg        <= '0;
            left_leads_reg <= 1'b0;
            dir_bits_reg   <= '0;
            ev_left_reg    <= 1'b0;
            ev_right_reg   <= 1'b0;
            ev_last_reg    <= 1'b0;
        end
        else if (cmd.commit)
        begin
            left_now_reg   <= new_left;
            right_now_reg  <= new_right;
            follow_reg     <= follow_val;
            gap_reg        <= lead_val - follow_val;
            togo_reg       <= lead_val;
            err_reg        <= '0;
            left_leads_reg <= left_leads;
            dir_bits_reg   <= {grow_r_reg, grow_l_reg};
            ev_left_reg    <= 1'b0;
            ev_right_reg   <= 1'b0;
            ev_last_reg    <= 1'b0;
        end
        else if (cmd.tick)
        begin
            if (busy)
            begin
                err_reg      <= err_next;
                togo_reg     <= togo_reg - LB'(1);
                ev_left_reg  <= left_leads_reg ? 1'b1 : fstep;
                ev_right_reg <= left_leads_reg ? fstep : 1'b1;
                ev_last_reg  <= togo_reg == LB'(1);
            end
            else
            begin
                ev_left_reg  <= 1'b0;
                ev_right_reg <= 1'b0;
                ev_last_reg  <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/polargraph_step_generator.sv @@
// ----------------------------------------------------------------------------
// polargraph_step_generator
// Two-string wall plotter step generator: string lengths from a pen target,
// then an interleaved step sequence for both motors, one step item per tick.
// ----------------------------------------------------------------------------
// A tick item goes from acceptance through the emit state into the output
// register once that is free, and so does a target that arrives during a
// running move (it is rejected). An accepted target first runs through the
// length units: each string has its own, with a bit-serial square over the
// magnitude bits (MAG = 24) and a restoring square root over the root bits
// (ROOT = 22), followed by the rounding, the move plan and the commit. One
// item is worked on at a time; a new item is taken while the previous result
// still waits in the output register. Configuration writes are taken in
// every cycle and must only be made while the block is idle. FRAC_BITS
// (0 to 8) sets the number of fraction bits of the target and anchor
// coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module polargraph_step_generator #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   item_valid,
    output logic                                        item_ready,
    input  wire pgsg_pkg::item_t                        item,
    output logic                                        result_valid,
    input  wire logic                                   result_ready,
    output pgsg_pkg::result_t                           result,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [pgsg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [pgsg_pkg::COORD_BITS-1:0]        cfg_data
);

    localparam int CB = pgsg_pkg::COORD_BITS;
    localparam int LB = pgsg_pkg::LEN_BITS;

    // Configuration registers.
    logic [CB-1:0] left_ax_reg, right_ax_reg, anchor_y_reg;
    logic          inv_left_reg, inv_right_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_ax_reg   <= '0;
            right_ax_reg  <= '0;
            anchor_y_reg  <= '0;
            inv_left_reg  <= 1'b0;
            inv_right_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pgsg_pkg::CFG_LEFT_ANCHOR_X:  left_ax_reg   <= cfg_data;
                pgsg_pkg::CFG_RIGHT_ANCHOR_X: right_ax_reg  <= cfg_data;
                pgsg_pkg::CFG_ANCHOR_Y:       anchor_y_reg  <= cfg_data;
                pgsg_pkg::CFG_INVERT_LEFT:    inv_left_reg  <= cfg_data[0];
                pgsg_pkg::CFG_INVERT_RIGHT:   inv_right_reg <= cfg_data[0];
                default:                      inv_left_reg  <= inv_left_reg;
            endcase
        end
    end

    // Sequencer state and item flags.
    pgsg_pkg::seq_state_t   state_reg, state_next;
    logic                   is_tick_reg, rej_reg;
    pgsg_pkg::step_cmd_t    cmd;
    pgsg_pkg::step_status_t status;
    logic                   accept, len_start, len_done, emit_load;
    logic                   l_done, r_done;
    logic [LB-1:0]          l_len, r_len;
    pgsg_pkg::result_t      result_reg, res_val;
    logic                   result_valid_reg;

    // Length units, one per string.
    pgsg_len_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_len_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (len_start),
        .pen_x    (item.pen_x),
        .pen_y    (item.pen_y),
        .anchor_x (left_ax_reg),
        .anchor_y (anchor_y_reg),
        .done     (l_done),
        .length   (l_len)
    );

    pgsg_len_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_len_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (len_start),
        .pen_x    (item.pen_x),
        .pen_y    (item.pen_y),
        .anchor_x (right_ax_reg),
        .anchor_y (anchor_y_reg),
        .done     (r_done),
        .length   (r_len)
    );

    // Move state and step interleave.
    pgsg_stepper u_stepper (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .new_left  (l_len),
        .new_right (r_len),
        .status    (status)
    );

    assign len_done = l_done && r_done;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgsg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.action == pgsg_pkg::ACT_TARGET && !status.busy)
                        state_next = pgsg_pkg::ST_LEN;
                    else
                        state_next = pgsg_pkg::ST_EMIT;
                end
            end
            pgsg_pkg::ST_LEN:    if (len_done) state_next = pgsg_pkg::ST_PLAN;
            pgsg_pkg::ST_PLAN:   state_next = pgsg_pkg::ST_COMMIT;
            pgsg_pkg::ST_COMMIT: state_next = pgsg_pkg::ST_EMIT;
            pgsg_pkg::ST_EMIT:   if (emit_load) state_next = pgsg_pkg::ST_IDLE;
            default:             state_next = pgsg_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        item_ready = (state_reg == pgsg_pkg::ST_IDLE);
        accept     = item_ready && item_valid;
        cmd.tick   = accept && (item.action == pgsg_pkg::ACT_TICK);
        len_start  = accept && (item.action == pgsg_pkg::ACT_TARGET) && !status.busy;
        cmd.plan   = (state_reg == pgsg_pkg::ST_PLAN);
        cmd.commit = (state_reg == pgsg_pkg::ST_COMMIT);
        emit_load  = (state_reg == pgsg_pkg::ST_EMIT) && (!result_valid_reg || result_ready);
    end

    // Result from the move state after the item; directions follow the
    // invert settings as they stand.
    always_comb
    begin
        res_val.step_left    = is_tick_reg && status.step_left;
        res_val.dir_left     = status.dir_bits[0] ^ inv_left_reg;
        res_val.step_right   = is_tick_reg && status.step_right;
        res_val.dir_right    = status.dir_bits[1] ^ inv_right_reg;
        res_val.busy_res     = status.busy;
        res_val.last_step    = is_tick_reg && status.last;
        res_val.rejected     = rej_reg;
        res_val.left_length  = status.left_len;
        res_val.right_length = status.right_len;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pgsg_pkg::ST_IDLE;
            is_tick_reg      <= 1'b0;
            rej_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                is_tick_reg <= (item.action == pgsg_pkg::ACT_TICK);
                rej_reg     <= (item.action == pgsg_pkg::ACT_TARGET) && status.busy;
            end
            if (emit_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (emit_load)
            result_reg <= res_val;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the polargraph step generator. Targets and step ticks are sent
// over the item channel while an in-bench model of the string kinematics and
// the two-motor Bresenham run predicts every result item, which is compared
// field by field as it leaves the block. Directed checks cover idle ticks,
// lead choice on ties, rejected targets, invert settings and coordinate
// extremes; a random walk through random anchor regions follows, and a
// saturated string length closes the run.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pgsg_pkg::*;

    localparam int FRAC_BITS = 4;
    localparam longint unsigned LEN_SPAN = 64'd1 << (LEN_BITS + FRAC_BITS);
    localparam longint COORD_HI = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    // Half width of a random work region, in 1/16 step units.
    localparam longint REGION_HALF = 1600;

    // Block ports; every input starts at a known value.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    item_t                 item_bus = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result_bus;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LEFT_ANCHOR_X;
    logic [COORD_BITS-1:0] cfg_data = '0;

    // Register copies held by the predictor.
    logic signed [COORD_BITS-1:0] anc_left_x = '0;
    logic signed [COORD_BITS-1:0] anc_right_x = '0;
    logic signed [COORD_BITS-1:0] anc_y = '0;
    logic                         flip_left = 1'b0;
    logic                         flip_right = 1'b0;

    // Plotter state held by the predictor.
    logic [LEN_BITS-1:0] len_left = '0;
    logic [LEN_BITS-1:0] len_right = '0;
    logic [LEN_BITS-1:0] lead_n = '0;
    logic [LEN_BITS-1:0] follow_n = '0;
    logic [LEN_BITS-1:0] ticks_due = '0;
    logic [LEN_BITS:0]   bres_err = '0;
    logic                left_is_lead = 1'b0;
    logic [1:0]          grow_bits = '0;

    result_t step_results_due[$];

    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int moves_started = 0;
    int rejects_seen = 0;
    int burst_left = 0;
    int unsigned rx_cycle = 0;

    polargraph_step_generator #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item_bus),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result_bus),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Kinematics and step sequence predictor
    // ------------------------------------------------------------------

    // Digit-by-digit integer square root, floor of the exact root.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned rem_v;
        longint unsigned trial;
        root = 0;
        rem_v = 0;
        for (int i = 31; i >= 0; i--)
        begin
            rem_v = (rem_v << 2) | ((v >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            root = root << 1;
            if (rem_v >= trial)
            begin
                rem_v = rem_v - trial;
                root = root | 64'd1;
            end
        end
        return root;
    endfunction

    // String length in whole steps, halves rounded up, saturated.
    function automatic logic [LEN_BITS-1:0] string_steps(longint dx, longint dy);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned root;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax >= LEN_SPAN || ay >= LEN_SPAN)
            return LEN_MAX;
        root = int_sqrt(((ax * ax + ay * ay) << 2) >> (2 * FRAC_BITS));
        root = (root + 64'd1) >> 1;
        if (root > LEN_MAX)
            return LEN_MAX;
        return root[LEN_BITS-1:0];
    endfunction

    function automatic result_t make_result(logic sl, logic sr, logic last, logic rej);
        result_t r;
        r.step_left    = sl;
        r.dir_left     = grow_bits[0] ^ flip_left;
        r.step_right   = sr;
        r.dir_right    = grow_bits[1] ^ flip_right;
        r.busy_res     = (ticks_due != 0);
        r.last_step    = last;
        r.rejected     = rej;
        r.left_length  = len_left;
        r.right_length = len_right;
        return r;
    endfunction

    // Advances the plotter state by one item and returns its result.
    function automatic result_t plan_and_step(item_t it);
        logic [LEN_BITS-1:0] new_l;
        logic [LEN_BITS-1:0] new_r;
        logic [LEN_BITS-1:0] dl;
        logic [LEN_BITS-1:0] dr;
        longint              dy;
        logic                follow_now;
        if (it.action == ACT_TARGET)
        begin
            // A target during a running move is dropped.
            if (ticks_due != 0)
            begin
                rejects_seen++;
                return make_result(1'b0, 1'b0, 1'b0, 1'b1);
            end
            dy = longint'(signed'(it.pen_y)) - longint'(anc_y);
            new_l = string_steps(longint'(signed'(it.pen_x)) - longint'(anc_left_x), dy);
            new_r = string_steps(longint'(signed'(it.pen_x)) - longint'(anc_right_x), dy);
            dl = (new_l > len_left) ? new_l - len_left : len_left - new_l;
            dr = (new_r > len_right) ? new_r - len_right : len_right - new_r;
            grow_bits = {new_r > len_right, new_l > len_left};
            // The right motor leads on a tie.
            left_is_lead = (dl > dr);
            lead_n = left_is_lead ? dl : dr;
            follow_n = left_is_lead ? dr : dl;
            ticks_due = lead_n;
            bres_err = '0;
            len_left = new_l;
            len_right = new_r;
            if (lead_n != 0)
                moves_started++;
            return make_result(1'b0, 1'b0, 1'b0, 1'b0);
        end
        if (ticks_due == 0)
            return make_result(1'b0, 1'b0, 1'b0, 1'b0);
        // One lead step, and a follower step when the error sum wraps.
        bres_err = bres_err + follow_n;
        follow_now = 1'b0;
        if (bres_err >= lead_n)
        begin
            bres_err = bres_err - lead_n;
            follow_now = 1'b1;
        end
        ticks_due = ticks_due - 1'b1;
        if (left_is_lead)
            return make_result(1'b1, follow_now, ticks_due == 0, 1'b0);
        return make_result(follow_now, 1'b1, ticks_due == 0, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------

    // Receiver runs through free flow, coin flips, short and long stalls.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0:    result_ready <= 1'b1;
            2'd1:    result_ready <= ($urandom_range(0, 1) == 1);
            2'd2:    result_ready <= (rx_cycle[2:0] > 3'd2);
            default: result_ready <= (rx_cycle[5:3] != 3'd0);
        endcase
    end

    task automatic report_field(input string name, input logic [LEN_BITS-1:0] want,
                                input logic [LEN_BITS-1:0] got);
        if (want !== got)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    endtask

    // Each result item is compared with the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (step_results_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, expected nothing, got %h",
                         $time, result_bus);
            end
            else
            begin
                want = step_results_due.pop_front();
                if (result_bus !== want)
                begin
                    errors++;
                    report_field("step_left", want.step_left, result_bus.step_left);
                    report_field("dir_left", want.dir_left, result_bus.dir_left);
                    report_field("step_right", want.step_right, result_bus.step_right);
                    report_field("dir_right", want.dir_right, result_bus.dir_right);
                    report_field("busy_res", want.busy_res, result_bus.busy_res);
                    report_field("last_step", want.last_step, result_bus.last_step);
                    report_field("rejected", want.rejected, result_bus.rejected);
                    report_field("left_length", want.left_length, result_bus.left_length);
                    report_field("right_length", want.right_length,
                                 result_bus.right_length);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------

    // Sends one item in bursts with random gaps; predicts on acceptance.
    task automatic send_item(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item_bus <= it;
        do
            @(posedge clk);
        while (!item_ready);
        step_results_due.push_back(plan_and_step(it));
        items_sent++;
    endtask

    task automatic send_target(input longint x, input longint y);
        item_t it;
        it.action = ACT_TARGET;
        it.pen_x = COORD_BITS'(x);
        it.pen_y = COORD_BITS'(y);
        send_item(it);
    endtask

    // Tick items carry random coordinates, which the block ignores.
    task automatic send_tick();
        item_t it;
        it.action = ACT_TICK;
        it.pen_x = COORD_BITS'($urandom);
        it.pen_y = COORD_BITS'($urandom);
        send_item(it);
    endtask

    task automatic finish_move();
        while (ticks_due != 0)
            send_tick();
    endtask

    // Holds the sender until every predicted result has come out.
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (step_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COORD_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_LEFT_ANCHOR_X:  anc_left_x = data;
            CFG_RIGHT_ANCHOR_X: anc_right_x = data;
            CFG_ANCHOR_Y:       anc_y = data;
            CFG_INVERT_LEFT:    flip_left = data[0];
            CFG_INVERT_RIGHT:   flip_right = data[0];
            default: ;
        endcase
    endtask

    // Writes all registers with the block idle; invert data carries noise above bit 0.
    task automatic write_config(input longint lax, input longint rax, input longint ay,
                                input logic inv_l, input logic inv_r);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_write(CFG_LEFT_ANCHOR_X, COORD_BITS'(lax));
        cfg_write(CFG_RIGHT_ANCHOR_X, COORD_BITS'(rax));
        cfg_write(CFG_ANCHOR_Y, COORD_BITS'(ay));
        cfg_write(CFG_INVERT_LEFT, {(COORD_BITS-1)'($urandom), inv_l});
        cfg_write(CFG_INVERT_RIGHT, {(COORD_BITS-1)'($urandom), inv_r});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic longint clamp_coord(longint v);
        if (v > COORD_HI)
            return COORD_HI;
        if (v < COORD_LO)
            return COORD_LO;
        return v;
    endfunction

    // Region centers lean toward both ends of the coordinate range.
    function automatic longint pick_coord();
        logic signed [COORD_BITS-1:0] c;
        case ($urandom_range(0, 5))
            0:       c = {1'b1, {(COORD_BITS-1){1'b0}}};
            1:       c = {1'b0, {(COORD_BITS-1){1'b1}}};
            default: c = COORD_BITS'($urandom);
        endcase
        return longint'(c);
    endfunction

    function automatic longint region_offset();
        return longint'($urandom_range(0, 2 * REGION_HALF)) - REGION_HALF;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset: a target onto the anchors starts no move, ticks do nothing.
    task automatic test_idle_ticks();
        send_target(0, 0);
        send_item(item_t'{action: ACT_TICK, pen_x: 24'h7FFFFF, pen_y: 24'h800000});
        send_item(item_t'{action: ACT_TICK, pen_x: 24'h800000, pen_y: 24'h7FFFFF});
    endtask

    // A tie lets the right motor lead; then the left leads with no follower.
    task automatic test_lead_choice();
        write_config(-32, 32, 0, 1'b0, 1'b0);
        send_target(0, 48);
        finish_move();
        send_target(-32, 16);
        finish_move();
        send_tick();
    endtask

    // Targets that arrive during a move are flagged and change nothing.
    task automatic test_reject_mid_move();
        send_target(0, 48);
        send_tick();
        send_item(item_t'{action: ACT_TARGET, pen_x: 24'h7FFFFF, pen_y: 24'h800000});
        send_item(item_t'{action: ACT_TARGET, pen_x: 24'h800000, pen_y: 24'h7FFFFF});
        finish_move();
    endtask

    // Invert settings apply at once, also to the held direction of an idle block.
    task automatic test_invert_change();
        write_config(-32, 32, 0, 1'b1, 1'b1);
        send_tick();
        send_target(40, 40);
        finish_move();
    endtask

    // Anchors and targets at both ends of the coordinate range.
    task automatic test_coord_extremes();
        write_config(COORD_LO, COORD_LO + 48, COORD_LO, 1'b1, 1'b0);
        send_target(COORD_LO, COORD_LO);
        finish_move();
        write_config(COORD_HI, COORD_HI - 48, COORD_HI, 1'b0, 1'b1);
        send_target(COORD_HI, COORD_HI);
        finish_move();
        send_target(COORD_HI - 32, COORD_HI - 32);
        finish_move();
    endtask

    // One random region: anchors near a center, then a walk of short moves
    // with rejected targets, stray items and idle ticks mixed in.
    task automatic run_region();
        longint cx;
        longint cy;
        longint ox;
        longint oy;
        item_t  stray;
        finish_move();
        cx = pick_coord();
        cy = pick_coord();
        write_config(clamp_coord(cx + region_offset()), clamp_coord(cx + region_offset()),
                     clamp_coord(cy + region_offset()), 1'($urandom), 1'($urandom));
        ox = 0;
        oy = 0;
        repeat ($urandom_range(10, 40))
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    ox = region_offset();
                    oy = region_offset();
                end
                1, 2: ;
                default:
                begin
                    ox = ox + longint'($urandom_range(0, 320)) - 160;
                    oy = oy + longint'($urandom_range(0, 320)) - 160;
                end
            endcase
            if (ox > REGION_HALF) ox = REGION_HALF;
            if (ox < -REGION_HALF) ox = -REGION_HALF;
            if (oy > REGION_HALF) oy = REGION_HALF;
            if (oy < -REGION_HALF) oy = -REGION_HALF;
            send_target(clamp_coord(cx + ox), clamp_coord(cy + oy));
            while (ticks_due != 0)
            begin
                case ($urandom_range(0, 19))
                    0: send_target(pick_coord(), pick_coord());
                    1:
                    begin
                        stray = item_t'({$urandom, $urandom});
                        send_item(stray);
                    end
                    default: send_tick();
                endcase
            end
            if ($urandom_range(0, 7) == 0)
                send_tick();
            if ($urandom_range(0, 14) == 0)
                wait_drained();
        end
    endtask

    task automatic test_random_regions();
        int stop_at;
        stop_at = items_sent + 1400;
        while (items_sent < stop_at)
            run_region();
    endtask

    // Both strings beyond the length range; the long move stays unfinished.
    task automatic test_saturated_length();
        finish_move();
        write_config(COORD_LO, COORD_HI, COORD_LO, 1'b0, 1'b1);
        send_target(COORD_HI, COORD_HI);
        repeat (6) send_tick();
        send_target(0, 0);
        send_tick();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ticks();
        test_lead_choice();
        test_reject_mid_move();
        test_invert_change();
        test_coord_extremes();
        test_random_regions();
        test_saturated_length();
        wait_drained();
        repeat (80) @(posedge clk);
        $display("Run covered %0d items and %0d results: %0d moves, %0d rejected targets,",
                 items_sent, results_checked, moves_started, rejects_seen);
        $display("random anchor regions, both coordinate extremes and a saturated length.");
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results still expected.", step_results_due.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pgsg_pkg.sv
rtl/core/pgsg_len_unit.sv
rtl/core/pgsg_stepper.sv
rtl/core/polargraph_step_generator.sv
verif/tb_top.sv
